[rtl/core/mfsk_pkg.sv]
// ----------------------------------------------------------------------------
// mfsk_pkg
// shared types and constants for the mfsk tone modulator
// ----------------------------------------------------------------------------
package mfsk_pkg;

  // symbol width codes held in the configuration register
  localparam logic SYM_4BIT = 1'b0;
  localparam logic SYM_2BIT = 1'b1;

  localparam int unsigned PHASE_W = 6;   // phase index into the cosine table
  localparam int unsigned TONE_W  = 5;   // tone multiple, 8..23
  localparam int unsigned SIS_W   = 8;   // sample-in-symbol counter
  localparam int unsigned SIB_W   = 2;   // symbol-in-byte index
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SMP_W   = 8;

  localparam logic [TONE_W-1:0]  TONE_BASE = 5'd8;
  // 125 mod 64, all phase arithmetic is mod 64
  localparam logic [PHASE_W-1:0] TONE_STEP = 6'd61;

  // floor(127 + 32*cos(2*pi*k/64)), quarter-wave entries exactly 127
  localparam logic [SMP_W-1:0] COS_TABLE [0:63] = '{
    8'd159, 8'd158, 8'd158, 8'd157, 8'd156, 8'd155, 8'd153, 8'd151,
    8'd149, 8'd147, 8'd144, 8'd142, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd123, 8'd120, 8'd117, 8'd114, 8'd111, 8'd109, 8'd106,
    8'd104, 8'd102, 8'd100, 8'd98,  8'd97,  8'd96,  8'd95,  8'd95,
    8'd95,  8'd95,  8'd95,  8'd96,  8'd97,  8'd98,  8'd100, 8'd102,
    8'd104, 8'd106, 8'd109, 8'd111, 8'd114, 8'd117, 8'd120, 8'd123,
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd142, 8'd144, 8'd147,
    8'd149, 8'd151, 8'd153, 8'd155, 8'd156, 8'd157, 8'd158, 8'd158
  };

  // request passed from the phase stage to the output stage
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               taken;
  } phase_req_t;

endpackage

[rtl/core/mfsk_tone_modulator.sv]
// ----------------------------------------------------------------------------
// mfsk_tone_modulator
// mfsk audio tone generator, one 8-bit sample per input request
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_      slave      tdata[7:0] data_byte, tuser[0] message_start
//  out_     master     tdata[7:0] sample,    tuser[0] byte_taken
//  cfg_     slave      data[0] two_bit_symbols, always ready
//
//  one request per cycle sustained while out_ does not stall
//  the symbol counters and phase index update in the cycle a request is taken;
//  the phase register and the result register form a two-deep pipeline
//  a stall on out_ backs up through both stages, in_tready drops only when
//  both hold data; synchronous active-low reset clears counters and mode
// ----------------------------------------------------------------------------
module mfsk_tone_modulator
  import mfsk_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_SYMBOL = 160
) (
  input  logic              clk,
  input  logic              rst_n,
  // input requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] message_start
  // result requests
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [SMP_W-1:0]  out_tdata,  // [7:0] sample
  output logic              out_tuser,  // [0] byte_taken
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data    // [0] two_bit_symbols
);

  localparam logic [SIS_W-1:0] SPS = SIS_W'(SAMPLES_PER_SYMBOL);

  logic               mode_r, mode_nxt;
  logic [PHASE_W-1:0] pcount_r, pcount_nxt;
  logic [SIS_W-1:0]   sis_r, sis_nxt;
  logic [SIB_W-1:0]   sib_r, sib_nxt;
  logic [BYTE_W-1:0]  hbyte_r, hbyte_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  phase_req_t         s1_req_r, s1_req_nxt;
  logic               s2_ready;

  // working values for the request being taken
  logic               accept;
  logic [PHASE_W-1:0] pc_cur;
  logic [SIS_W-1:0]   sis_cur, sis_inc;
  logic [SIB_W-1:0]   sib_cur, sib_inc;
  logic               take;
  logic [BYTE_W-1:0]  hb_cur;
  logic [1:0]         sym2;
  logic [3:0]         sym4;
  logic [TONE_W-1:0]  tone;
  logic [PHASE_W-1:0] tone6, n_cur, tone_off, phase;

  assign cfg_ready = 1'b1;
  assign in_tready = !s1_valid_r || s2_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // message start restarts the byte period and the sample number
    pc_cur  = in_tuser ? '0 : pcount_r;
    sis_cur = in_tuser ? '0 : sis_r;
    sib_cur = in_tuser ? '0 : sib_r;
    take    = (sis_cur == '0) && (sib_cur == '0);
    hb_cur  = take ? in_tdata : hbyte_r;

    // symbols go out most significant bits first
    case (sib_cur)
      2'd0:    sym2 = hb_cur[7:6];
      2'd1:    sym2 = hb_cur[5:4];
      2'd2:    sym2 = hb_cur[3:2];
      default: sym2 = hb_cur[1:0];
    endcase
    // in 4-bit mode an odd index picks the low nibble
    sym4 = sib_cur[0] ? hb_cur[3:0] : hb_cur[7:4];

    if (mode_r == SYM_2BIT) begin
      tone = TONE_BASE + {1'b0, sym2, 2'b00};
    end else begin
      tone = TONE_BASE + {1'b0, sym4};
    end

    // k = m*(125m + n) mod 64, only the low six bits are ever needed
    n_cur    = pc_cur + 6'd1;
    tone6    = {1'b0, tone};
    tone_off = PHASE_W'(tone6 * TONE_STEP) + n_cur;
    phase    = PHASE_W'(tone6 * tone_off);

    // counter advance
    sis_inc = sis_cur + 8'd1;
    sib_inc = sib_cur + 2'd1;
  end

  always_comb begin
    mode_nxt   = mode_r;
    pcount_nxt = pcount_r;
    sis_nxt    = sis_r;
    sib_nxt    = sib_r;
    hbyte_nxt  = hbyte_r;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_data;
    end

    if (accept) begin
      pcount_nxt = n_cur;
      hbyte_nxt  = hb_cur;
      if (sis_inc >= SPS) begin
        sis_nxt = '0;
        // 4-bit mode carries two symbols a byte, 2-bit mode four
        if (mode_r == SYM_4BIT && sib_inc >= 2'd2) begin
          sib_nxt = '0;
        end else begin
          sib_nxt = sib_inc;
        end
      end else begin
        sis_nxt = sis_inc;
        sib_nxt = sib_cur;
      end
    end
  end

  // phase stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_req_nxt   = s1_req_r;
    if (in_tready) begin
      s1_valid_nxt     = accept;
      s1_req_nxt.phase = phase;
      s1_req_nxt.taken = take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= SYM_4BIT;
      pcount_r   <= '0;
      sis_r      <= '0;
      sib_r      <= '0;
      hbyte_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      pcount_r   <= pcount_nxt;
      sis_r      <= sis_nxt;
      sib_r      <= sib_nxt;
      hbyte_r    <= hbyte_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    s1_req_r <= s1_req_nxt;
  end

  // table lookup and result register
  mfsk_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (s1_valid_r),
    .req        (s1_req_r),
    .req_ready  (s2_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/mfsk_out_stage.sv]
// ----------------------------------------------------------------------------
// mfsk_out_stage
// cosine table lookup into the registered result stage
// ----------------------------------------------------------------------------
module mfsk_out_stage
  import mfsk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  phase_req_t       req,
  output logic             req_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [SMP_W-1:0] out_tdata,
  output logic             out_tuser
);

  logic             valid_r, valid_nxt;
  logic [SMP_W-1:0] sample_r, sample_nxt;
  logic             taken_r, taken_nxt;

  assign req_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    taken_nxt  = taken_r;
    if (req_ready) begin
      valid_nxt  = req_valid;
      sample_nxt = COS_TABLE[req.phase];
      taken_nxt  = req.taken;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    sample_r <= sample_nxt;
    taken_r  <= taken_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = sample_r;
  assign out_tuser  = taken_r;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking mfsk tone modulator bench: a directed table of extremes,
// restarts and mode changes, then random message phases in both symbol
// widths, results checked against typed rows or a cycle-free tone predictor
// ----------------------------------------------------------------------------
module testbench;
  import mfsk_pkg::*;

  localparam int unsigned SYMBOL_LEN  = 160;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned NUM_ROWS    = 20;

  // floor(127 + 32*cos(2*pi*k/64)), the quarter-wave points held at 127
  localparam logic [SMP_W-1:0] CARRIER_WAVE [0:63] = '{
    8'd159, 8'd158, 8'd158, 8'd157, 8'd156, 8'd155, 8'd153, 8'd151,
    8'd149, 8'd147, 8'd144, 8'd142, 8'd139, 8'd136, 8'd133, 8'd130,
    8'd127, 8'd123, 8'd120, 8'd117, 8'd114, 8'd111, 8'd109, 8'd106,
    8'd104, 8'd102, 8'd100, 8'd98,  8'd97,  8'd96,  8'd95,  8'd95,
    8'd95,  8'd95,  8'd95,  8'd96,  8'd97,  8'd98,  8'd100, 8'd102,
    8'd104, 8'd106, 8'd109, 8'd111, 8'd114, 8'd117, 8'd120, 8'd123,
    8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd142, 8'd144, 8'd147,
    8'd149, 8'd151, 8'd153, 8'd155, 8'd156, 8'd157, 8'd158, 8'd158
  };

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             taken;
  } tone_result_t;

  // one line of the directed table; typed rows carry their own answer
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data;
    logic              start;
    logic              typed;
    logic [SMP_W-1:0]  sample;
    logic              taken;
  } stim_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata   = '0;   // [7:0] data_byte
  logic              in_tuser   = 1'b0; // [0] message_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [SMP_W-1:0]  out_tdata;         // [7:0] sample
  logic              out_tuser;         // [0] byte_taken
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic              cfg_data   = 1'b0; // [0] two_bit_symbols

  // predictor copy of the modulator state
  logic              tone_mode;
  logic [PHASE_W-1:0] tone_phase;
  logic [SIS_W-1:0]  tone_sample_no;
  logic [SIB_W-1:0]  tone_symbol_no;
  logic [BYTE_W-1:0] tone_byte;

  tone_result_t      expected_q [$];
  stim_row_t         directed_rows [0:NUM_ROWS-1];
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       snd_idle_pct = 0;
  int unsigned       rcv_idle_pct = 0;

  mfsk_tone_modulator #(
    .SAMPLES_PER_SYMBOL (SYMBOL_LEN)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, well above the slowest legal run with both stall profiles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // advance the predictor by one accepted request and return its sample
  function automatic tone_result_t tone_predict(input logic [BYTE_W-1:0] data,
                                                input logic start);
    tone_result_t res;
    int unsigned  sym, mult, n, k, per_byte, nxt;
    if (start) begin
      tone_phase     = '0;
      tone_sample_no = '0;
      tone_symbol_no = '0;
    end
    res.taken = 1'b0;
    // a new byte period latches the data byte
    if (tone_sample_no == 0 && tone_symbol_no == 0) begin
      tone_byte = data;
      res.taken = 1'b1;
    end
    if (tone_mode == SYM_2BIT) begin
      sym  = (int'(tone_byte) >> (2 * (3 - int'(tone_symbol_no)))) & 3;
      mult = 8 + 4 * sym;
    end else begin
      // odd symbol index picks the low nibble, even the high one
      sym  = tone_symbol_no[0] ? int'(tone_byte[3:0]) : int'(tone_byte[7:4]);
      mult = 8 + sym;
    end
    n          = (int'(tone_phase) + 1) & 63;
    k          = (mult * (125 * mult + n)) & 63;
    tone_phase = n[PHASE_W-1:0];
    res.sample = CARRIER_WAVE[k[PHASE_W-1:0]];
    per_byte = (tone_mode == SYM_2BIT) ? 4 : 2;
    if (int'(tone_sample_no) + 1 >= SYMBOL_LEN) begin
      tone_sample_no = '0;
      nxt            = (int'(tone_symbol_no) + 1) & 3;
      tone_symbol_no = (nxt >= per_byte) ? '0 : nxt[SIB_W-1:0];
    end else begin
      tone_sample_no = tone_sample_no + 1'b1;
    end
    return res;
  endfunction

  // offer one input request, predict on acceptance; called on a falling edge
  task automatic send_request(input logic [BYTE_W-1:0] data, input logic start,
                              input logic typed, input tone_result_t typed_res);
    tone_result_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = tone_predict(data, start);
    expected_q.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // stop offering and wait until every pending sample has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // symbol width write, only with the modulator idle
  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tone_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    tone_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: sample %0d byte_taken %0d", out_tdata, out_tuser);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata !== want.sample || out_tuser !== want.taken) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: sample exp %0d got %0d, byte_taken exp %0d got %0d",
                     want.sample, out_tdata, want.taken, out_tuser);
        end
      end
    end
  end

  initial begin
    tone_result_t typed_res;
    tone_result_t no_res;
    logic         phase_mode;
    logic         start_first;
    logic         targeted;
    logic         start;
    logic [BYTE_W-1:0] data;
    int unsigned  phase_len;

    tone_mode      = SYM_4BIT;
    tone_phase     = '0;
    tone_sample_no = '0;
    tone_symbol_no = '0;
    tone_byte      = '0;
    no_res         = '0;

    // mode, data_byte, message_start, typed, sample, byte_taken
    directed_rows = '{
      // first request after reset opens a byte period, m = 8, n = 1
      '{SYM_4BIT, 8'h00, 1'b0, 1'b1, 8'd149, 1'b1},
      // data ignored mid-symbol, n = 2 lands on a quarter-wave point
      '{SYM_4BIT, 8'hFF, 1'b0, 1'b1, 8'd127, 1'b0},
      // restart goes back to n = 1 and latches again
      '{SYM_4BIT, 8'h00, 1'b1, 1'b1, 8'd149, 1'b1},
      '{SYM_4BIT, 8'hFF, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'h0F, 1'b0, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'hF0, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'h80, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'h01, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'hA5, 1'b0, 1'b0, 8'd0,   1'b0},
      // two-bit symbols, all-zero byte gives the lowest tone again
      '{SYM_2BIT, 8'h00, 1'b1, 1'b1, 8'd149, 1'b1},
      '{SYM_2BIT, 8'hFF, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_2BIT, 8'h55, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_2BIT, 8'hAA, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_2BIT, 8'hC3, 1'b0, 1'b0, 8'd0,   1'b0},
      '{SYM_2BIT, 8'h3C, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_2BIT, 8'h7E, 1'b0, 1'b0, 8'd0,   1'b0},
      // back to four-bit symbols part way into a byte
      '{SYM_4BIT, 8'h5A, 1'b0, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'hFF, 1'b1, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'h00, 1'b0, 1'b0, 8'd0,   1'b0},
      '{SYM_4BIT, 8'hE7, 1'b1, 1'b0, 8'd0,   1'b0}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under the first idle profile
    snd_idle_pct = 21;
    rcv_idle_pct = 75;
    write_mode(directed_rows[0].mode);
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].mode != tone_mode) begin
        drain_results();
        write_mode(directed_rows[r].mode);
      end
      typed_res.sample = directed_rows[r].sample;
      typed_res.taken  = directed_rows[r].taken;
      send_request(directed_rows[r].data, directed_rows[r].start,
                   directed_rows[r].typed, typed_res);
    end

    // random message phases; the mode is rewritten between phases without
    // restarting, so a width change often lands part way into a byte
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 3) begin
        snd_idle_pct = 21;
        rcv_idle_pct = 75;
      end else if (p < 7) begin
        snd_idle_pct = 75;
        rcv_idle_pct = 21;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      targeted = (p == 2);
      if (p == 2) begin
        // two-bit message stopped on its third or fourth symbol ...
        phase_mode  = SYM_2BIT;
        start_first = 1'b1;
        phase_len   = $urandom_range(330, 630);
      end else if (p == 3) begin
        // ... then four-bit symbols carry on from that symbol index
        phase_mode  = SYM_4BIT;
        start_first = 1'b0;
        phase_len   = $urandom_range(100, 250);
      end else begin
        phase_mode  = $urandom_range(0, 1) ? SYM_2BIT : SYM_4BIT;
        start_first = 1'($urandom_range(0, 1));
        phase_len   = $urandom_range(100, 250);
      end
      drain_results();
      write_mode(phase_mode);
      for (int i = 0; i < phase_len; i++) begin
        // mostly clean messages, now and then a restart mid-byte
        start = (i == 0 && start_first) || (!targeted && $urandom_range(0, 199) == 0);
        case ($urandom_range(0, 15))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom_range(0, 255));
        endcase
        send_request(data, start, 1'b0, no_res);
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mfsk_pkg.sv
rtl/core/mfsk_out_stage.sv
rtl/core/mfsk_tone_modulator.sv
verif/testbench.sv
